[design/orb_pkg.sv]
// ---------------------------------------------------------------------------
// orb_pkg: shared types and codes of the overwriting ring buffer
// Action codes, the data word type and the control groups passed between
// the pointer unit, the storage memory and the top level.
// ---------------------------------------------------------------------------
package orb_pkg;

  localparam int WORD_W    = 32;
  localparam int ACT_W     = 2;
  localparam int CFG_W     = 5;
  localparam int CAP_RESET = 16;

  localparam logic [ACT_W-1:0] ACT_PUSH     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP_HEAD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_TAIL = 2'd2;

  typedef logic signed [WORD_W-1:0] orb_word_t;

  // memory access issued for one request
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } orb_mem_ctl_t;

  // result flags of one request, as they stand after it
  typedef struct packed {
    logic has_data;
    logic status;
    logic is_empty;
    logic is_full;
  } orb_res_t;

endpackage

[design/overwriting_ring_buffer_unit.sv]
// ---------------------------------------------------------------------------
// overwriting_ring_buffer_unit: ring buffer of signed words, overwrite on full
// Input channel: in_action (push, pop front, pop back) and in_value, under
// in_valid / in_stall. Result channel: out_data, out_status, out_is_empty,
// out_is_full under out_valid / out_stall, one result per request.
// Configuration: cfg_we with cfg_wdata writes the capacity (clamped to
// 1..DEPTH) and empties the buffer; write only while the block is idle.
// An accepted request enters the hold stage, then the output register.
// Throughput: one request per cycle while out_stall is low, set by the single
// memory port (at most one access per request) and the one-deep hold stage.
// Reset: pointers and flags clear, capacity returns to 16 (or DEPTH if
// smaller); stored words are left as they are.
// When the receiver stalls, the result holds in the output register, one
// more request completes into the hold stage, then in_stall rises.
// ---------------------------------------------------------------------------
module overwriting_ring_buffer_unit #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [orb_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [orb_pkg::ACT_W-1:0]     in_action,
  input  logic signed [orb_pkg::WORD_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [orb_pkg::WORD_W-1:0] out_data,
  output logic                          out_status,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  orb_pkg::orb_mem_ctl_t mem_ctl;
  logic [IDX_W-1:0]      mem_addr;
  orb_pkg::orb_word_t    mem_rdata;
  orb_pkg::orb_res_t     res;

  logic acc, load;

  // hold stage: request issued, memory data arriving
  logic              pend_r, pend_nxt;
  orb_pkg::orb_res_t pend_res_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  orb_pkg::orb_word_t out_data_r;
  orb_pkg::orb_res_t  out_res_r;

  assign load     = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && !load;
  assign acc      = in_valid && !in_stall;

  orb_ptr #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .acc      (acc),
    .action   (in_action),
    .mem_ctl  (mem_ctl),
    .mem_addr (mem_addr),
    .res      (res)
  );

  orb_mem #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .addr (mem_addr),
    .wdata(in_value),
    .rdata(mem_rdata)
  );

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = 1'b0;
    end
    if (acc) begin
      pend_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_res_r <= res;
    end
    if (load) begin
      out_res_r  <= pend_res_r;
      out_data_r <= pend_res_r.has_data ? mem_rdata : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign out_status   = out_res_r.status;
  assign out_is_empty = out_res_r.is_empty;
  assign out_is_full  = out_res_r.is_full;

  a_stall_only_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r |-> !in_stall)
    else $error("input stalled with empty hold stage");

  a_accept_fills_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> pend_r)
    else $error("accepted request did not reach hold stage");

  a_failed_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status |-> (out_data_r == '0))
    else $error("failed pop returned nonzero data");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.is_full && out_res_r.is_empty))
    else $error("result reports full and empty together");

  a_failed_pop_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.status |-> !mem_ctl.rd_en && !mem_ctl.wr_en)
    else $error("failed pop touched memory");

endmodule

[design/orb_mem.sv]
// ---------------------------------------------------------------------------
// orb_mem: word storage of the ring buffer
// Single-port synchronous memory, one write or one read per cycle, read
// data registered and held until the next read.
// ---------------------------------------------------------------------------
module orb_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  orb_pkg::orb_mem_ctl_t ctl,
  input  logic [IDX_W-1:0]     addr,
  input  orb_pkg::orb_word_t   wdata,
  output orb_pkg::orb_word_t   rdata
);

  orb_pkg::orb_word_t mem [DEPTH];
  orb_pkg::orb_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/orb_ptr.sv]
// ---------------------------------------------------------------------------
// orb_ptr: pointer and flag unit of the ring buffer
// Holds the read index, write index, full flag and the clamped capacity.
// Decodes each accepted request into at most one memory access and the flags.
// ---------------------------------------------------------------------------
module orb_ptr #(
  parameter int DEPTH = 16,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [orb_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           acc,
  input  logic [orb_pkg::ACT_W-1:0]      action,
  output orb_pkg::orb_mem_ctl_t          mem_ctl,
  output logic [IDX_W-1:0]               mem_addr,
  output orb_pkg::orb_res_t              res
);

  localparam int CAP_RST = (DEPTH < orb_pkg::CAP_RESET) ? DEPTH : orb_pkg::CAP_RESET;

  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic [IDX_W-1:0] wr_r, wr_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic             full_r, full_nxt;

  logic [IDX_W-1:0] rd_inc, wr_inc, wr_dec, rd_push;
  logic             empty;

  assign rd_inc  = (rd_r == last_r) ? '0 : rd_r + IDX_W'(1);
  assign wr_inc  = (wr_r == last_r) ? '0 : wr_r + IDX_W'(1);
  assign wr_dec  = (wr_r == '0) ? last_r : wr_r - IDX_W'(1);
  assign rd_push = full_r ? rd_inc : rd_r;
  assign empty   = (rd_r == wr_r) && !full_r;

  always_comb begin
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    full_nxt     = full_r;
    last_nxt     = last_r;
    mem_ctl      = '0;
    mem_addr     = wr_r;
    res.has_data = 1'b0;
    res.status   = 1'b0;
    if (acc) begin
      case (action)
        orb_pkg::ACT_PUSH: begin
          // overwrite the oldest entry when full
          mem_ctl.wr_en = 1'b1;
          rd_nxt        = rd_push;
          wr_nxt        = wr_inc;
          full_nxt      = (rd_push == wr_inc);
        end
        orb_pkg::ACT_POP_HEAD: begin
          if (empty) begin
            res.status = 1'b1;
          end else begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = rd_r;
            res.has_data  = 1'b1;
            rd_nxt        = rd_inc;
            full_nxt      = 1'b0;
          end
        end
        orb_pkg::ACT_POP_TAIL: begin
          if (empty) begin
            res.status = 1'b1;
          end else begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = wr_dec;
            res.has_data  = 1'b1;
            wr_nxt        = wr_dec;
            full_nxt      = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cfg_we) begin
      // new capacity empties the buffer; clamp to 1..DEPTH
      rd_nxt   = '0;
      wr_nxt   = '0;
      full_nxt = 1'b0;
      if (cfg_wdata == '0) begin
        last_nxt = '0;
      end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
        last_nxt = IDX_W'(DEPTH - 1);
      end else begin
        last_nxt = IDX_W'(cfg_wdata - orb_pkg::CFG_W'(1));
      end
    end
    res.is_empty = (rd_nxt == wr_nxt) && !full_nxt;
    res.is_full  = full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r   <= '0;
      wr_r   <= '0;
      full_r <= 1'b0;
      last_r <= IDX_W'(CAP_RST - 1);
    end else begin
      rd_r   <= rd_nxt;
      wr_r   <= wr_nxt;
      full_r <= full_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

[tb/sv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for overwriting_ring_buffer_unit
// Drives push, pop-front, pop-back and unused requests under several
// capacities and idle/stall mixes. A scoreboard tracks its own copy of the
// ring and compares every result field against the predicted one.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int RING_DEPTH = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [orb_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    orb_pkg::orb_word_t data;
    logic status;
    logic is_empty;
    logic is_full;
  } ring_result_t;

  class ring_scoreboard;
    orb_pkg::orb_word_t words[RING_DEPTH];
    int unsigned front_idx;
    int unsigned back_idx;
    int unsigned cap;
    bit full;
    ring_result_t pending_q[$];
    int errors;

    function new();
      front_idx = 0;
      back_idx = 0;
      cap = orb_pkg::CAP_RESET;
      full = 0;
      errors = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void set_capacity(logic [orb_pkg::CFG_W-1:0] v);
      if (v == 0) cap = 1;
      else if (v > RING_DEPTH) cap = RING_DEPTH;
      else cap = v;
      front_idx = 0;
      back_idx = 0;
      full = 0;
    endfunction

    function bit ring_empty();
      return front_idx == back_idx && !full;
    endfunction

    function int unsigned step_idx(int unsigned i);
      return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function void note_request(logic [orb_pkg::ACT_W-1:0] act, orb_pkg::orb_word_t val);
      ring_result_t r;
      r = '0;
      case (act)
        orb_pkg::ACT_PUSH: begin
          words[back_idx] = val;
          if (full) front_idx = step_idx(front_idx);
          back_idx = step_idx(back_idx);
          if (front_idx == back_idx) full = 1;
        end
        orb_pkg::ACT_POP_HEAD: begin
          if (ring_empty()) begin
            r.status = 1'b1;
          end else begin
            r.data = words[front_idx];
            front_idx = step_idx(front_idx);
            full = 0;
          end
        end
        orb_pkg::ACT_POP_TAIL: begin
          if (ring_empty()) begin
            r.status = 1'b1;
          end else begin
            back_idx = (back_idx == 0) ? cap - 1 : back_idx - 1;
            r.data = words[back_idx];
            full = 0;
          end
        end
        default: ;
      endcase
      r.is_empty = ring_empty();
      r.is_full = full;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(orb_pkg::orb_word_t data, logic status, logic is_empty,
                               logic is_full);
      ring_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result data=%0d status=%0b", $time, data, status);
        errors++;
        return;
      end
      e = pending_q[0];
      pending_q.delete(0);
      if (data !== e.data) begin
        $display("%0t: data expected %0d actual %0d", $time, e.data, data);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status expected %0b actual %0b", $time, e.status, status);
        errors++;
      end
      if (is_empty !== e.is_empty) begin
        $display("%0t: is_empty expected %0b actual %0b", $time, e.is_empty, is_empty);
        errors++;
      end
      if (is_full !== e.is_full) begin
        $display("%0t: is_full expected %0b actual %0b", $time, e.is_full, is_full);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [orb_pkg::CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [orb_pkg::ACT_W-1:0] in_action;
  orb_pkg::orb_word_t in_value;
  logic out_valid;
  logic out_stall;
  orb_pkg::orb_word_t out_data;
  logic out_status;
  logic out_is_empty;
  logic out_is_full;

  ring_scoreboard ring_sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  overwriting_ring_buffer_unit #(.DEPTH(RING_DEPTH)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .out_status(out_status),
    .out_is_empty(out_is_empty),
    .out_is_full(out_is_full)
  );

  // note requests before checking results so the order within an edge is fixed
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ring_sb.note_request(in_action, in_value);
      if (out_valid && !out_stall)
        ring_sb.check_result(out_data, out_status, out_is_empty, out_is_full);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no request or result moving", $time);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_request(input logic [orb_pkg::ACT_W-1:0] act,
                              input orb_pkg::orb_word_t val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ring_sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [orb_pkg::CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    ring_sb.set_capacity(v);
    cfg_we <= 1'b0;
  endtask

  function automatic orb_pkg::orb_word_t random_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [orb_pkg::ACT_W-1:0] random_action(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return ACT_UNUSED;
    if (r < 3 + push_pct) return orb_pkg::ACT_PUSH;
    return $urandom_range(1) ? orb_pkg::ACT_POP_HEAD : orb_pkg::ACT_POP_TAIL;
  endfunction

  initial begin
    logic [orb_pkg::CFG_W-1:0] seg_caps[8];
    int push_pct;
    seg_caps = '{5'd31, 5'd0, 5'd1, 5'd17, 5'd3, 5'd16, 5'd5, 5'd0};
    seg_caps[7] = orb_pkg::CFG_W'($urandom_range(31));
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_action <= orb_pkg::ACT_PUSH;
    in_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, unused code, extreme words, at reset capacity
    send_request(orb_pkg::ACT_POP_HEAD, 32'h1234_5678);
    send_request(orb_pkg::ACT_POP_TAIL, '1);
    send_request(ACT_UNUSED, 32'h5555_5555);
    send_request(orb_pkg::ACT_PUSH, 32'h7FFF_FFFF);
    send_request(orb_pkg::ACT_PUSH, 32'h8000_0000);
    send_request(orb_pkg::ACT_PUSH, '1);
    send_request(orb_pkg::ACT_PUSH, '0);
    send_request(orb_pkg::ACT_POP_TAIL, '0);
    send_request(orb_pkg::ACT_POP_HEAD, '0);
    send_request(ACT_UNUSED, 32'hAAAA_AAAA);
    send_request(orb_pkg::ACT_POP_HEAD, '0);
    send_request(orb_pkg::ACT_POP_HEAD, '0);
    send_request(orb_pkg::ACT_POP_HEAD, '0);

    // directed: fill a two-entry ring, overwrite the oldest, pop both ends
    write_capacity(5'd2);
    send_request(orb_pkg::ACT_PUSH, 32'h0000_0011);
    send_request(orb_pkg::ACT_PUSH, 32'h0000_0022);
    send_request(orb_pkg::ACT_PUSH, 32'h0000_0033);
    send_request(orb_pkg::ACT_PUSH, 32'hFFFF_FF44);
    send_request(orb_pkg::ACT_POP_TAIL, '0);
    send_request(orb_pkg::ACT_POP_HEAD, '0);
    send_request(orb_pkg::ACT_POP_TAIL, '0);
    send_request(orb_pkg::ACT_PUSH, 32'h0000_0055);
    send_request(orb_pkg::ACT_POP_HEAD, '0);

    for (int seg = 0; seg < 8; seg++) begin
      write_capacity(seg_caps[seg]);
      case (seg % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 52; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 52; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      push_pct = 50;
      for (int n = 0; n < 150; n++) begin
        // shift the push bias now and then so the ring fills and drains
        if (n % 20 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 80;
            1: push_pct = 45;
            default: push_pct = 20;
          endcase
        end
        send_request(random_action(push_pct), random_word());
      end
    end

    drain();
    if (ring_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
design/orb_pkg.sv
design/orb_mem.sv
design/orb_ptr.sv
design/overwriting_ring_buffer_unit.sv
tb/sv/tb_top.sv
